// ===== rtl/dhcd_pkg.sv =====
package dhcd_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } dhcd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] device_id;
    logic [15:0] power_tenths;
    logic [15:0] peak_power_tenths;
    logic [43:0] energy_ws;
  } dhcd_out_t;

  // Per-frame link state carried between the registers and the destuffer
  typedef struct packed {
    logic [1:0] phase;
    logic [2:0] ones_run;
    logic [7:0] asm_byte;
    logic [2:0] asm_bits;
  } dhcd_link_t;

  // One completed payload byte out of the destuffer
  typedef struct packed {
    logic       push;
    logic [7:0] data;
  } dhcd_push_t;

  localparam logic [17:0] SEED_BITS     = 18'h1D3AC;
  localparam logic [17:0] TAP_MASK      = 18'h31801;
  localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_RESIDUE   = 16'hF0B8;
  localparam logic [6:0]  FRAME_LEN_RST = 7'd60;
  localparam logic [6:0]  PCNT_MAX      = 7'h7F;

  localparam logic [1:0] PH_OPEN   = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_CLOSED = 2'd2;
  localparam logic [1:0] PH_NOFLAG = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_NO_OPEN  = 3'd2;
  localparam logic [2:0] ST_NO_CLOSE = 3'd3;
  localparam logic [2:0] ST_BAD_LEN  = 3'd4;
  localparam logic [2:0] ST_BAD_CRC  = 3'd5;

  localparam dhcd_link_t LINK_RST = '{phase: PH_OPEN, ones_run: 3'd0,
                                      asm_byte: 8'd0, asm_bits: 3'd0};

  // Payload bytes that the result fields draw from
  localparam int CAP_SLOTS = 14;

  function automatic logic [6:0] cap_index(input int slot);
    logic [6:0] idx;
    unique case (slot)
      0:       idx = 7'd0;
      1:       idx = 7'd1;
      2:       idx = 7'd2;
      3:       idx = 7'd12;
      4:       idx = 7'd13;
      5:       idx = 7'd14;
      6:       idx = 7'd15;
      7:       idx = 7'd16;
      8:       idx = 7'd17;
      9:       idx = 7'd18;
      10:      idx = 7'd19;
      11:      idx = 7'd33;
      12:      idx = 7'd34;
      default: idx = 7'd35;
    endcase
    return idx;
  endfunction

  // Reflected CRC-CCITT, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [7:0] d;
    d = data ^ crc[7:0];
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'd0, d[7:4]} ^ {5'd0, d, 3'b000};
  endfunction

endpackage

// ===== rtl/descramble_hdlc_crc_deframer_core.sv =====
// Deframer for scrambled, bit-stuffed HDLC meter frames.
// Input channel (in_valid/in_stall/in_data): one raw radio byte per item,
// with frame_start marking the first byte of a frame. Bits are descrambled
// MSB first, inverted, checked for the opening flag, destuffed, packed LSB
// first into payload bytes and run through a reflected CRC-CCITT.
// Result channel (out_valid/out_stall/out_data): one item on the last raw
// byte of each frame, carrying status and the decoded meter fields (all
// fields zero unless status is ok).
// Configuration: cfg_wr_en/cfg_wr_data write frame_length (raw bytes per
// frame); write it only while no frame is in flight.
// Throughput: one byte per cycle unless a waiting result is stalled; the
// whole byte is handled by single-pass logic between the input register and
// the result register, which takes the result as its last byte moves on.
// Reset (synchronous, rst_n low): empty both registers, restart the frame
// state and load frame_length with 60.
// Stall: while out_stall holds a waiting result, the byte in the input
// register waits too and in_stall rises; nothing is lost or repeated.
module descramble_hdlc_crc_deframer_core #(
  parameter int PAYLOAD_LEN = 41,
  parameter int MAX_FRAME   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dhcd_pkg::dhcd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dhcd_pkg::dhcd_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [6:0]          cfg_wr_data
);
  import dhcd_pkg::*;

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam logic [6:0]    PL_C    = 7'(PAYLOAD_LEN);
  localparam logic [LW-1:0] MIN_LEN = LW'(PAYLOAD_LEN + 2);
  localparam logic [LW-1:0] MAXF    = LW'(MAX_FRAME);

  // Input register
  logic     in_valid_r;
  dhcd_in_t in_data_r;

  // Result register
  logic      out_valid_r;
  dhcd_out_t out_data_r;

  // Frame state
  logic [6:0]    frame_len_r;
  logic [17:0]   lfsr_r, lfsr_nxt;
  logic [CW-1:0] raw_cnt_r, raw_cnt_nxt;
  dhcd_link_t    link_r, link_nxt;
  logic [6:0]    pcnt_r, pcnt_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    cap_r   [CAP_SLOTS];
  logic [7:0]    cap_nxt [CAP_SLOTS];

  // Working values for the byte in the input register
  logic          adv;
  logic          start;
  logic [17:0]   lfsr_cur, lfsr_step;
  dhcd_link_t    link_cur, link_step;
  logic [CW-1:0] cnt_cur, cnt_step;
  logic [6:0]    pcnt_cur, pcnt_step;
  logic [15:0]   crc_cur, crc_step;
  logic [7:0]    clear_byte;
  dhcd_push_t    push;
  logic          store_en;
  logic [LW-1:0] len_eff;
  logic          emit;
  dhcd_out_t     res;
  logic [15:0]   w33s;

  // Move the input byte on whenever the result slot is free or being taken
  assign adv       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FRAME_LEN_RST;
    end else if (cfg_wr_en) begin
      frame_len_r <= cfg_wr_data;
    end
  end

  // frame_start restarts everything before this byte is taken
  assign start    = in_data_r.frame_start;
  assign lfsr_cur = start ? SEED_BITS : lfsr_r;
  assign link_cur = start ? LINK_RST : link_r;
  assign cnt_cur  = start ? '0 : raw_cnt_r;
  assign pcnt_cur = start ? 7'd0 : pcnt_r;
  assign crc_cur  = start ? CRC_INIT : crc_r;

  dhcd_descrambler u_descr (
    .lfsr_in    (lfsr_cur),
    .raw_byte   (in_data_r.rx_byte),
    .lfsr_out   (lfsr_step),
    .clear_byte (clear_byte)
  );

  dhcd_deframer u_defr (
    .link_in    (link_cur),
    .clear_byte (clear_byte),
    .link_out   (link_step),
    .push_out   (push)
  );

  // Store and checksum only the first PAYLOAD_LEN bytes; keep counting past it
  assign store_en  = push.push && (pcnt_cur < PL_C);
  assign crc_step  = store_en ? crc_byte(crc_cur, push.data) : crc_cur;
  assign pcnt_step = (push.push && pcnt_cur != PCNT_MAX) ? pcnt_cur + 7'd1 : pcnt_cur;
  assign cnt_step  = cnt_cur + CW'(1);

  // Keep only the payload bytes the result fields need
  always_comb begin
    for (int k = 0; k < CAP_SLOTS; k++) begin
      cap_nxt[k] = (store_en && pcnt_cur == cap_index(k)) ? push.data : cap_r[k];
    end
  end

  // Clamp frame length to 1..MAX_FRAME
  always_comb begin
    len_eff = LW'(frame_len_r);
    if (len_eff == '0) len_eff = LW'(1);
    if (len_eff > MAXF) len_eff = MAXF;
  end

  assign emit = LW'(cnt_step) >= len_eff;

  // Slots: 0..2 bytes 0..2, 3..10 bytes 12..19, 11..13 bytes 33..35
  assign w33s = {cap_nxt[11][3:0], cap_nxt[12], cap_nxt[13][7:4]};

  always_comb begin
    res = '0;
    priority if (len_eff < MIN_LEN) begin
      res.status = ST_SHORT;
    end else if (link_step.phase == PH_NOFLAG) begin
      res.status = ST_NO_OPEN;
    end else if (link_step.phase != PH_CLOSED) begin
      res.status = ST_NO_CLOSE;
    end else if (pcnt_step != PL_C) begin
      res.status = ST_BAD_LEN;
    end else if (crc_step != CRC_RESIDUE) begin
      res.status = ST_BAD_CRC;
    end else begin
      res.status            = ST_OK;
      res.device_id         = {cap_nxt[0][3:0], cap_nxt[1], cap_nxt[2][7:4]};
      res.power_tenths      = {cap_nxt[6][3:0], cap_nxt[7], cap_nxt[8][7:4]};
      res.peak_power_tenths = {cap_nxt[8][3:0], cap_nxt[9], cap_nxt[10][7:4]};
      res.energy_ws         = {w33s, cap_nxt[3], cap_nxt[4], cap_nxt[5], cap_nxt[6][7:4]};
    end
  end

  // Return to the idle frame state after the last byte
  assign lfsr_nxt    = emit ? SEED_BITS : lfsr_step;
  assign link_nxt    = emit ? LINK_RST : link_step;
  assign raw_cnt_nxt = emit ? '0 : cnt_step;
  assign pcnt_nxt    = emit ? 7'd0 : pcnt_step;
  assign crc_nxt     = emit ? CRC_INIT : crc_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r    <= SEED_BITS;
      link_r    <= LINK_RST;
      raw_cnt_r <= '0;
      pcnt_r    <= 7'd0;
      crc_r     <= CRC_INIT;
    end else if (adv) begin
      lfsr_r    <= lfsr_nxt;
      link_r    <= link_nxt;
      raw_cnt_r <= raw_cnt_nxt;
      pcnt_r    <= pcnt_nxt;
      crc_r     <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < CAP_SLOTS; k++) begin
        cap_r[k] <= cap_nxt[k];
      end
    end
  end

  // Load a result on the last byte; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_data_r <= res;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit) |=> (raw_cnt_r == '0 && link_r.phase == PH_OPEN && pcnt_r == 7'd0))
    else $error("frame state not restarted after last byte");

  a_closed_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (link_r.phase == PH_CLOSED) |-> (link_r.ones_run == 3'd0))
    else $error("ones run left over after closing flag");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |->
      (out_data_r.device_id == '0 && out_data_r.power_tenths == '0 &&
       out_data_r.peak_power_tenths == '0 && out_data_r.energy_ws == '0))
    else $error("failed frame carries nonzero fields");

endmodule

// ===== rtl/dhcd_descrambler.sv =====
module dhcd_descrambler (
  input  logic [17:0] lfsr_in,
  input  logic [7:0]  raw_byte,
  output logic [17:0] lfsr_out,
  output logic [7:0]  clear_byte
);
  import dhcd_pkg::*;

  logic [17:0] hist;
  logic [7:0]  ob;

  // Descramble MSB first, shift the received bit into the history
  always_comb begin
    hist = lfsr_in;
    ob   = '0;
    for (int i = 7; i >= 0; i--) begin
      ob[i] = raw_byte[i] ^ (^(hist & TAP_MASK));
      hist  = {hist[16:0], raw_byte[i]};
    end
    lfsr_out   = hist;
    clear_byte = ~ob;
  end

endmodule

// ===== rtl/dhcd_deframer.sv =====
module dhcd_deframer (
  input  dhcd_pkg::dhcd_link_t link_in,
  input  logic [7:0]           clear_byte,
  output dhcd_pkg::dhcd_link_t link_out,
  output dhcd_pkg::dhcd_push_t push_out
);
  import dhcd_pkg::*;

  logic [1:0] ph;
  logic [2:0] ones;
  logic [7:0] ab;
  logic [2:0] nb;
  logic       b;

  always_comb begin
    ph       = link_in.phase;
    ones     = link_in.ones_run;
    ab       = link_in.asm_byte;
    nb       = link_in.asm_bits;
    b        = 1'b0;
    push_out = '0;
    if (ph == PH_OPEN) begin
      ph = (clear_byte == FLAG_BYTE) ? PH_DATA : PH_NOFLAG;
    end else if (ph == PH_DATA) begin
      for (int i = 7; i >= 0; i--) begin
        if (ph == PH_DATA) begin
          b = clear_byte[i];
          if (ones >= 3'd5 && !b) begin
            // drop stuffed zero; six ones then zero closes the frame
            if (ones == 3'd6) ph = PH_CLOSED;
            ones = 3'd0;
          end else begin
            ones = b ? ((ones == 3'd7) ? 3'd7 : ones + 3'd1) : 3'd0;
            ab   = {b, ab[7:1]};
            if (nb == 3'd7) begin
              push_out.push = 1'b1;
              push_out.data = ab;
            end
            nb = nb + 3'd1;
          end
        end
      end
    end
    link_out.phase    = ph;
    link_out.ones_run = ones;
    link_out.asm_byte = ab;
    link_out.asm_bits = nb;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

// Stream raw radio bytes into the deframer and check each frame-end report.
// Frames are built in the clear (flag, stuffed payload with its FCS, closing
// flag), then run through a scrambler that undoes the block's descrambler.
// Every accepted byte is also run through a bit-exact decoder kept here.
// That decoder queues the report that the block must give at frame end.
module tb;
  import dhcd_pkg::*;

  localparam int PAYLOAD_LEN    = 41;
  localparam int MAX_FRAME      = 64;
  localparam int PAY_AW         = $clog2(PAYLOAD_LEN);
  localparam int IDLE_PCT       = 21;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 5000;

  // Shapes of generated frames
  typedef enum {
    FK_GOOD, FK_BAD_CRC, FK_SHORT_PAY, FK_LONG_PAY, FK_NO_OPEN, FK_NO_CLOSE, FK_LONG_RUN
  } frame_kind_t;

  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  dhcd_in_t   in_data     = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  dhcd_out_t  out_data;
  logic       cfg_wr_en   = 1'b0;
  logic [6:0] cfg_wr_data = '0;

  descramble_hdlc_crc_deframer_core #(
    .PAYLOAD_LEN(PAYLOAD_LEN),
    .MAX_FRAME  (MAX_FRAME)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hold reset at the start, then release it once
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Decoder state: mirrors the block, one byte at a time
  // ---------------------------------------------------------------------------
  logic [6:0]  frame_cfg = FRAME_LEN_RST;
  logic [17:0] scr_hist;
  logic [6:0]  raw_cnt;
  logic [2:0]  ones_run;
  logic [7:0]  asm_byte;
  logic [2:0]  asm_bits;
  logic [6:0]  pay_cnt;
  logic [15:0] crc_acc;
  logic [1:0]  phase;
  logic [7:0]  pay_mem [0:PAYLOAD_LEN-1];

  dhcd_out_t awaited_reports[$];   // reports owed by the block, oldest first
  dhcd_in_t  byte_feed[$];         // bytes waiting for the driver
  dhcd_in_t  frame_bytes[$];       // bytes of the phase being built
  bit        plain_bits[$];        // descrambled bit stream of one frame
  logic [7:0] payload_draft[$];    // payload of one frame, FCS included
  int        gen_run;              // ones since the last zero, for stuffing

  logic      steady    = 1'b0;     // no idling on either side
  logic      want_hold = 1'b0;     // ask the receiver for one long hold-off
  logic      hold_done = 1'b0;
  int        hold_left = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  dhcd_out_t oldest;

  // Raw bytes per frame as the block counts them: zero acts as one, cap at MAX_FRAME
  function automatic int frame_span(logic [6:0] v);
    if (v == 0) return 1;
    if (v > MAX_FRAME) return MAX_FRAME;
    return int'(v);
  endfunction

  // Reflected CRC-CCITT, bit-serial
  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
    c = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  function automatic void link_clear();
    scr_hist = SEED_BITS;
    raw_cnt  = '0;
    ones_run = '0;
    asm_byte = '0;
    asm_bits = '0;
    pay_cnt  = '0;
    crc_acc  = CRC_INIT;
    phase    = PH_OPEN;
  endfunction

  // Drop stuffed zeros, close on six ones, pack kept bits LSB first
  function automatic void destuff(logic [7:0] plain);
    logic b;
    for (int k = 7; k >= 0 && phase == PH_DATA; k--) begin
      b = plain[k];
      if (ones_run >= 3'd5 && !b) begin
        if (ones_run == 3'd6) phase = PH_CLOSED;
        ones_run = '0;
      end else begin
        if (b) ones_run = (ones_run < 3'd7) ? ones_run + 3'd1 : 3'd7;
        else   ones_run = '0;
        asm_byte = {b, asm_byte[7:1]};
        asm_bits = asm_bits + 3'd1;
        if (asm_bits == 3'd0) begin
          // Bytes beyond the payload size count toward the length only
          if (pay_cnt < PAYLOAD_LEN) begin
            pay_mem[pay_cnt[PAY_AW-1:0]] = asm_byte;
            crc_acc = crc_step(crc_acc, asm_byte);
          end
          if (pay_cnt != PCNT_MAX) pay_cnt = pay_cnt + 7'd1;
        end
      end
    end
  endfunction

  // 16-bit big-endian word at payload byte n, optionally taken 4 bits further on
  function automatic logic [15:0] pay_word(int n, bit nibble);
    logic [23:0] w;
    w = {pay_mem[n], pay_mem[n+1], pay_mem[n+2]};
    return nibble ? w[19:4] : w[23:8];
  endfunction

  // Advance the decoder by one accepted byte; queue a report at frame end
  function automatic void decode_byte(dhcd_in_t it);
    logic [7:0]  plain;
    logic [15:0] w33, w12, w14;
    dhcd_out_t   r;
    int          span;
    if (it.frame_start) link_clear();
    plain = '0;
    for (int k = 7; k >= 0; k--) begin
      plain    = {plain[6:0], it.rx_byte[k] ^ (^(scr_hist & TAP_MASK))};
      scr_hist = {scr_hist[16:0], it.rx_byte[k]};
    end
    plain = ~plain;
    if (phase == PH_OPEN)      phase = (plain == FLAG_BYTE) ? PH_DATA : PH_NOFLAG;
    else if (phase == PH_DATA) destuff(plain);
    if (raw_cnt != 7'h7F) raw_cnt = raw_cnt + 7'd1;
    span = frame_span(frame_cfg);
    if (raw_cnt < span) return;
    r = '0;
    if (span < PAYLOAD_LEN + 2)        r.status = ST_SHORT;
    else if (phase == PH_NOFLAG)       r.status = ST_NO_OPEN;
    else if (phase != PH_CLOSED)       r.status = ST_NO_CLOSE;
    else if (pay_cnt != PAYLOAD_LEN)   r.status = ST_BAD_LEN;
    else if (crc_acc != CRC_RESIDUE)   r.status = ST_BAD_CRC;
    else begin
      r.status            = ST_OK;
      r.device_id         = pay_word(0, 1'b1);
      r.power_tenths      = pay_word(15, 1'b1);
      r.peak_power_tenths = pay_word(17, 1'b1);
      w33 = pay_word(33, 1'b1);
      w12 = pay_word(12, 1'b0);
      w14 = pay_word(14, 1'b0);
      r.energy_ws = {w33, 28'd0} | {16'd0, w12, 12'd0} | {32'd0, w14[15:4]};
    end
    awaited_reports.push_back(r);
    link_clear();
  endfunction

  // ---------------------------------------------------------------------------
  // Frame construction
  // ---------------------------------------------------------------------------
  function automatic void put_msb_first(logic [7:0] v);
    for (int k = 7; k >= 0; k--) plain_bits.push_back(v[k]);
  endfunction

  // Send a payload byte LSB first; insert a zero after five ones
  function automatic void stuff_byte(logic [7:0] v);
    for (int k = 0; k < 8; k++) begin
      plain_bits.push_back(v[k]);
      if (v[k]) begin
        gen_run++;
        if (gen_run == 5) begin
          plain_bits.push_back(1'b0);
          gen_run = 0;
        end
      end else begin
        gen_run = 0;
      end
    end
  endfunction

  function automatic void stage_byte(logic [7:0] v, logic fs);
    frame_bytes.push_back({v, fs});
  endfunction

  // Lay out one frame in the clear; the payload ends in its FCS, low byte first
  function automatic void build_frame(frame_kind_t kind, fill_t fill);
    int          n, run_at;
    logic [15:0] fcs;
    logic [7:0]  v;
    plain_bits.delete();
    payload_draft.delete();
    gen_run = 0;
    n = PAYLOAD_LEN;
    if (kind == FK_SHORT_PAY)     n = $urandom_range(PAYLOAD_LEN - 1, 3);
    else if (kind == FK_LONG_PAY) n = $urandom_range(PAYLOAD_LEN + 9, PAYLOAD_LEN + 1);
    fcs = CRC_INIT;
    for (int i = 0; i < n - 2; i++) begin
      if (fill == FILL_ONES)       v = 8'hFF;
      else if (fill == FILL_ZEROS) v = 8'h00;
      else                         v = 8'($urandom);
      payload_draft.push_back(v);
      fcs = crc_step(fcs, v);
    end
    fcs = ~fcs;
    payload_draft.push_back(fcs[7:0]);
    payload_draft.push_back(fcs[15:8]);
    if (kind == FK_BAD_CRC) begin
      run_at = $urandom_range(n - 1);
      payload_draft[run_at] = payload_draft[run_at] ^ (8'h01 << $urandom_range(7));
    end
    // A long run drops its trailing zero like a stuffed one but does not close the frame
    run_at = (kind == FK_LONG_RUN) ? $urandom_range(n - 1) : -1;
    put_msb_first((kind == FK_NO_OPEN) ? 8'($urandom) : FLAG_BYTE);
    for (int i = 0; i < n; i++) begin
      if (i == run_at) begin
        repeat (8) plain_bits.push_back(1'b1);
        plain_bits.push_back(1'b0);
        gen_run = 0;
      end
      stuff_byte(payload_draft[i]);
    end
    if (kind != FK_NO_CLOSE) put_msb_first(FLAG_BYTE);
  endfunction

  // Pad the frame with noise, invert and scramble it; stage the first keep bytes
  function automatic void scramble_frame(int span, logic fs, int keep);
    logic [17:0] h;
    logic [7:0]  raw;
    logic        b;
    h = SEED_BITS;
    while (plain_bits.size() < span * 8) plain_bits.push_back(1'($urandom));
    for (int i = 0; i < keep; i++) begin
      for (int k = 7; k >= 0; k--) begin
        b      = ~plain_bits[i * 8 + 7 - k] ^ (^(h & TAP_MASK));
        h      = {h[16:0], b};
        raw[k] = b;
      end
      stage_byte(raw, (i == 0) ? fs : 1'b0);
    end
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 58) return FK_GOOD;
    if (r < 66) return FK_BAD_CRC;
    if (r < 72) return FK_SHORT_PAY;
    if (r < 79) return FK_LONG_PAY;
    if (r < 85) return FK_NO_OPEN;
    if (r < 91) return FK_NO_CLOSE;
    return FK_LONG_RUN;
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing: runs on falling edges, drives the register port on rising ones
  // ---------------------------------------------------------------------------

  // Wait until nothing is queued, offered or owed, then let the pipeline settle
  task automatic wait_idle();
    while (byte_feed.size() != 0 || in_valid || awaited_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [6:0] v);
    frame_cfg = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // Hand the staged bytes to the driver; pause the sender once at a random
  // point until every owed report is in, then send the rest
  task automatic dispatch_stage();
    int split;
    split = (frame_bytes.size() > 1) ? $urandom_range(frame_bytes.size() - 1, 1)
                                     : frame_bytes.size();
    for (int i = 0; i < split; i++) byte_feed.push_back(frame_bytes[i]);
    wait_idle();
    for (int i = split; i < frame_bytes.size(); i++) byte_feed.push_back(frame_bytes[i]);
    wait_idle();
    frame_bytes.delete();
  endtask

  // One setting of frame_length: mostly well-formed frames with random content,
  // some broken ones, and now and then a frame cut short by a restart
  task automatic run_phase(input logic [6:0] cfg, input int target);
    int    span, keep, r;
    logic  need_start;
    fill_t fill;
    write_cfg(cfg);
    span       = frame_span(cfg);
    need_start = 1'b0;
    while (frame_bytes.size() < target || need_start) begin
      r = $urandom_range(19);
      if (r == 0)      fill = FILL_ONES;
      else if (r == 1) fill = FILL_ZEROS;
      else             fill = FILL_RANDOM;
      build_frame(pick_kind(), fill);
      keep = (span > 1 && $urandom_range(9) == 0) ? $urandom_range(span - 1, 1) : span;
      // After a clean frame end the next frame may open without frame_start
      scramble_frame(span, need_start || ($urandom_range(3) != 0), keep);
      need_start = (keep < span);
    end
    dispatch_stage();
  endtask

  initial begin
    link_clear();
    while (!rst_n) @(negedge clk);

    // Reset length, one good frame of all-ones payload: heaviest stuffing
    build_frame(FK_GOOD, FILL_ONES);
    scramble_frame(frame_span(frame_cfg), 1'b1, frame_span(frame_cfg));
    dispatch_stage();

    // One-byte frames: every byte ends a frame; drive raw byte extremes
    write_cfg(7'd1);
    stage_byte(8'h00, 1'b1);
    stage_byte(8'hFF, 1'b0);
    stage_byte(8'h7E, 1'b1);
    stage_byte(8'h80, 1'b0);
    stage_byte(8'h01, 1'b1);
    stage_byte(8'hFF, 1'b1);
    stage_byte(8'h00, 1'b0);
    stage_byte(8'hAA, 1'b0);
    stage_byte(8'h55, 1'b1);
    dispatch_stage();

    // Zero length acts as one
    write_cfg(7'd0);
    stage_byte(8'h7E, 1'b0);
    stage_byte(8'hC3, 1'b1);
    stage_byte(8'h3C, 1'b0);
    dispatch_stage();

    run_phase(7'd43, 150);
    run_phase(7'd64, 100);
    // Long receiver hold-off while every byte yields a report: fill the block
    want_hold = 1'b1;
    run_phase(7'd1, 120);
    run_phase(7'd127, 150);
    // Long stretch with no idling on either side
    steady = 1'b1;
    run_phase(7'd56, 200);
    steady = 1'b0;
    run_phase(7'd20, 100);
    run_phase(7'd50, 150);
    run_phase(7'd0, 40);
    run_phase(7'd42, 100);
    run_phase(7'd58, 150);
    run_phase(7'd45, 100);
    run_phase(7'd60, 100);
    run_phase(7'd100, 100);

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued bytes, idle at random, hold a byte while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data);
      // Advance only once the offered byte is taken or nothing is offered
      if (!in_valid || !in_stall) begin
        if (byte_feed.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= byte_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken report with the oldest owed one; stall at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("report item with no frame end owed: status %0d", out_data.status);
          mismatches++;
        end else begin
          oldest = awaited_reports.pop_front();
          if (out_data.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_data.status);
            mismatches++;
          end
          if (out_data.device_id !== oldest.device_id) begin
            $error("device_id: expected %0h, got %0h", oldest.device_id, out_data.device_id);
            mismatches++;
          end
          if (out_data.power_tenths !== oldest.power_tenths) begin
            $error("power_tenths: expected %0h, got %0h",
                   oldest.power_tenths, out_data.power_tenths);
            mismatches++;
          end
          if (out_data.peak_power_tenths !== oldest.peak_power_tenths) begin
            $error("peak_power_tenths: expected %0h, got %0h",
                   oldest.peak_power_tenths, out_data.peak_power_tenths);
            mismatches++;
          end
          if (out_data.energy_ws !== oldest.energy_ws) begin
            $error("energy_ws: expected %0h, got %0h", oldest.energy_ws, out_data.energy_ws);
            mismatches++;
          end
        end
      end
      // Count down a long hold-off here, independent of the sender
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (want_hold && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
